/* rtl/core/ghpm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ghpm_pkg: shared types and constants of the greedy hit pair matcher
// Store sizes, field widths, request and record codes, and the structs that
// travel between the controller, the hit store and the distance pipeline.
// ----------------------------------------------------------------------------
package ghpm_pkg;

    localparam int MAX_HITS = 16;
    localparam int IDX_W    = $clog2(MAX_HITS);
    localparam int CNT_W    = $clog2(MAX_HITS + 1);
    localparam int COORD_W  = 20;
    localparam int POS_W    = 2 * COORD_W;
    localparam int ABS_W    = COORD_W + 1;
    localparam int DIST_W   = 22;

    localparam logic [DIST_W-1:0] DIST_MAX_RST = DIST_W'(500);

    typedef enum logic [1:0] {
        FN_TRUTH = 2'd0,
        FN_RECO  = 2'd1,
        FN_RUN   = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        KIND_RECO  = 2'd0,
        KIND_TRUTH = 2'd1,
        KIND_SUM   = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_DECIDE,
        ST_RECO_RD,
        ST_RECO_PUT,
        ST_TRUTH_RD,
        ST_TRUTH_PUT,
        ST_SUM
    } state_t;

    typedef struct packed {
        logic             truth_we;
        logic             reco_we;
        logic [IDX_W-1:0] addr;
        logic [POS_W-1:0] pos;
    } store_wr_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  addr;
        logic [DIST_W-1:0] dval;
    } dist_wr_t;

    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] t;
        logic [IDX_W-1:0] r;
    } pair_tag_t;

    typedef struct packed {
        logic              vld;
        logic [IDX_W-1:0]  t;
        logic [IDX_W-1:0]  r;
        logic [DIST_W-1:0] dval;
    } cand_t;

endpackage
`default_nettype wire

/* rtl/core/greedy_hit_pair_matcher.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_hit_pair_matcher: greedy nearest truth/reco hit pairing
// Stores truth and reco hits, pairs them by least Manhattan distance below
// dist_max on a run request, and emits reco, truth and summary records.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Payload
//  hit       hit_valid/hit_stall   func, coord_u, coord_v
//  rec       rec_valid/rec_stall   kind, index, matched, partner, distance,
//                                  match_count, truth_count, reco_count,
//                                  overflow, last
//  cfg       cfg_we                cfg_wdata (dist_max)
//
// Load requests are taken back to back.
// A run request performs R match rounds over all T * N pairs, where T and
// N are the truth and reco fills and R is the number of pairs formed plus
// one, at one pair read per cycle from the position memories.
// Each hit record takes a distance memory read, then the output register,
// and records wait while rec_stall is held.
// hit_stall is high from a run request until its summary is registered.
// After reset the stores are empty and dist_max is 500.
// ----------------------------------------------------------------------------
module greedy_hit_pair_matcher (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [ghpm_pkg::DIST_W-1:0]   cfg_wdata,
    input  wire logic                          hit_valid,
    output logic                               hit_stall,
    input  wire logic [1:0]                    func,
    input  wire logic signed [ghpm_pkg::COORD_W-1:0] coord_u,
    input  wire logic signed [ghpm_pkg::COORD_W-1:0] coord_v,
    output logic                               rec_valid,
    input  wire logic                          rec_stall,
    output logic [1:0]                         kind,
    output logic [ghpm_pkg::IDX_W-1:0]         index,
    output logic                               matched,
    output logic [ghpm_pkg::IDX_W-1:0]         partner,
    output logic [ghpm_pkg::DIST_W-1:0]        distance,
    output logic [ghpm_pkg::CNT_W-1:0]         match_count,
    output logic [ghpm_pkg::CNT_W-1:0]         truth_count,
    output logic [ghpm_pkg::CNT_W-1:0]         reco_count,
    output logic                               overflow,
    output logic                               last
);
    import ghpm_pkg::*;

    logic [DIST_W-1:0] dist_max_reg;
    store_wr_t         store_wr;
    dist_wr_t          dist_wr;
    logic [IDX_W-1:0]  truth_raddr;
    logic [IDX_W-1:0]  reco_raddr;
    logic [IDX_W-1:0]  dist_raddr;
    logic [POS_W-1:0]  truth_rdata;
    logic [POS_W-1:0]  reco_rdata;
    logic [DIST_W-1:0] dist_rdata;
    pair_tag_t         issue;
    cand_t             cand;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_max_reg <= DIST_MAX_RST;
        end
        else if (cfg_we)
        begin
            dist_max_reg <= cfg_wdata;
        end
    end

    ghpm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .dist_max    (dist_max_reg),
        .hit_valid   (hit_valid),
        .hit_stall   (hit_stall),
        .func        (func),
        .coord_u     (coord_u),
        .coord_v     (coord_v),
        .store_wr    (store_wr),
        .truth_raddr (truth_raddr),
        .reco_raddr  (reco_raddr),
        .dist_wr     (dist_wr),
        .dist_raddr  (dist_raddr),
        .dist_rdata  (dist_rdata),
        .issue       (issue),
        .cand        (cand),
        .rec_valid   (rec_valid),
        .rec_stall   (rec_stall),
        .kind        (kind),
        .index       (index),
        .matched     (matched),
        .partner     (partner),
        .distance    (distance),
        .match_count (match_count),
        .truth_count (truth_count),
        .reco_count  (reco_count),
        .overflow    (overflow),
        .last        (last)
    );

    ghpm_hit_store u_store (
        .clk         (clk),
        .store_wr    (store_wr),
        .truth_raddr (truth_raddr),
        .reco_raddr  (reco_raddr),
        .dist_wr     (dist_wr),
        .dist_raddr  (dist_raddr),
        .truth_rdata (truth_rdata),
        .reco_rdata  (reco_rdata),
        .dist_rdata  (dist_rdata)
    );

    ghpm_dist_unit u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .truth_pos (truth_rdata),
        .reco_pos  (reco_rdata),
        .cand      (cand)
    );

endmodule
`default_nettype wire

/* rtl/core/ghpm_hit_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ghpm_hit_store: hit position and pair distance memories
// Truth and reco positions, each packed as {v, u}, plus the distance of each
// formed pair kept per truth index. All reads are registered.
// ----------------------------------------------------------------------------
module ghpm_hit_store (
    input  wire logic                          clk,
    input  wire ghpm_pkg::store_wr_t           store_wr,
    input  wire logic [ghpm_pkg::IDX_W-1:0]    truth_raddr,
    input  wire logic [ghpm_pkg::IDX_W-1:0]    reco_raddr,
    input  wire ghpm_pkg::dist_wr_t            dist_wr,
    input  wire logic [ghpm_pkg::IDX_W-1:0]    dist_raddr,
    output logic [ghpm_pkg::POS_W-1:0]         truth_rdata,
    output logic [ghpm_pkg::POS_W-1:0]         reco_rdata,
    output logic [ghpm_pkg::DIST_W-1:0]        dist_rdata
);
    import ghpm_pkg::*;

    logic [POS_W-1:0]  truth_mem [MAX_HITS];
    logic [POS_W-1:0]  reco_mem  [MAX_HITS];
    logic [DIST_W-1:0] dist_mem  [MAX_HITS];

    logic [POS_W-1:0]  truth_rdata_reg;
    logic [POS_W-1:0]  reco_rdata_reg;
    logic [DIST_W-1:0] dist_rdata_reg;

    // Loads, the pair scan and the record walk never overlap in time, so a
    // write and a read of the same entry cannot collide.
    always_ff @(posedge clk)
    begin
        if (store_wr.truth_we)
        begin
            truth_mem[store_wr.addr] <= store_wr.pos;
        end
        truth_rdata_reg <= truth_mem[truth_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (store_wr.reco_we)
        begin
            reco_mem[store_wr.addr] <= store_wr.pos;
        end
        reco_rdata_reg <= reco_mem[reco_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (dist_wr.we)
        begin
            dist_mem[dist_wr.addr] <= dist_wr.dval;
        end
        dist_rdata_reg <= dist_mem[dist_raddr];
    end

    assign truth_rdata = truth_rdata_reg;
    assign reco_rdata  = reco_rdata_reg;
    assign dist_rdata  = dist_rdata_reg;

endmodule
`default_nettype wire

/* rtl/core/ghpm_dist_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ghpm_dist_unit: Manhattan distance pipeline
// Follows the pair tag alongside the store read, registers |du| and |dv|,
// and presents their sum as a candidate for the running minimum.
// ----------------------------------------------------------------------------
module ghpm_dist_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire ghpm_pkg::pair_tag_t        issue,
    input  wire logic [ghpm_pkg::POS_W-1:0] truth_pos,
    input  wire logic [ghpm_pkg::POS_W-1:0] reco_pos,
    output ghpm_pkg::cand_t                 cand
);
    import ghpm_pkg::*;

    pair_tag_t        tag1_reg;
    pair_tag_t        tag2_reg;
    logic [ABS_W-1:0] du_reg;
    logic [ABS_W-1:0] dv_reg;
    logic [ABS_W-1:0] du_next;
    logic [ABS_W-1:0] dv_next;

    function automatic logic [ABS_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
        logic [ABS_W-1:0] diff;
        begin
            diff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
            abs_diff = diff[ABS_W-1] ? (~diff + ABS_W'(1)) : diff;
        end
    endfunction

    always_comb
    begin
        du_next = abs_diff(truth_pos[COORD_W-1:0], reco_pos[COORD_W-1:0]);
        dv_next = abs_diff(truth_pos[POS_W-1:COORD_W], reco_pos[POS_W-1:COORD_W]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else
        begin
            tag1_reg <= issue;
            tag2_reg <= tag1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        du_reg <= du_next;
        dv_reg <= dv_next;
    end

    // The sum of two coordinate differences always fits the distance field.
    always_comb
    begin
        cand.vld  = tag2_reg.vld;
        cand.t    = tag2_reg.t;
        cand.r    = tag2_reg.r;
        cand.dval = DIST_W'(du_reg) + DIST_W'(dv_reg);
    end

endmodule
`default_nettype wire

/* rtl/core/ghpm_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ghpm_ctrl: load, match and record sequencer
// Fills the stores, runs match rounds over all free pairs, commits the best
// pair of each round while it lies below dist_max, then walks the records into the output register.
// ----------------------------------------------------------------------------
module ghpm_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [ghpm_pkg::DIST_W-1:0]   dist_max,
    input  wire logic                          hit_valid,
    output logic                               hit_stall,
    input  wire logic [1:0]                    func,
    input  wire logic [ghpm_pkg::COORD_W-1:0]  coord_u,
    input  wire logic [ghpm_pkg::COORD_W-1:0]  coord_v,
    output ghpm_pkg::store_wr_t                store_wr,
    output logic [ghpm_pkg::IDX_W-1:0]         truth_raddr,
    output logic [ghpm_pkg::IDX_W-1:0]         reco_raddr,
    output ghpm_pkg::dist_wr_t                 dist_wr,
    output logic [ghpm_pkg::IDX_W-1:0]         dist_raddr,
    input  wire logic [ghpm_pkg::DIST_W-1:0]   dist_rdata,
    output ghpm_pkg::pair_tag_t                issue,
    input  wire ghpm_pkg::cand_t               cand,
    output logic                               rec_valid,
    input  wire logic                          rec_stall,
    output logic [1:0]                         kind,
    output logic [ghpm_pkg::IDX_W-1:0]         index,
    output logic                               matched,
    output logic [ghpm_pkg::IDX_W-1:0]         partner,
    output logic [ghpm_pkg::DIST_W-1:0]        distance,
    output logic [ghpm_pkg::CNT_W-1:0]         match_count,
    output logic [ghpm_pkg::CNT_W-1:0]         truth_count,
    output logic [ghpm_pkg::CNT_W-1:0]         reco_count,
    output logic                               overflow,
    output logic                               last
);
    import ghpm_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  truth_fill_reg, truth_fill_next;
    logic [CNT_W-1:0]  reco_fill_reg, reco_fill_next;
    logic              dropped_reg, dropped_next;
    logic [CNT_W-1:0]  nmatch_reg, nmatch_next;
    logic [IDX_W-1:0]  t_reg, t_next;
    logic [IDX_W-1:0]  r_reg, r_next;
    logic [IDX_W-1:0]  e_reg, e_next;
    logic              found_reg, found_next;
    logic [DIST_W-1:0] best_reg, best_next;
    logic [IDX_W-1:0]  bt_reg, bt_next;
    logic [IDX_W-1:0]  br_reg, br_next;
    logic [MAX_HITS-1:0] truth_has_reg, truth_has_next;
    logic [MAX_HITS-1:0] reco_has_reg, reco_has_next;
    logic [IDX_W-1:0]  truth_link_reg [MAX_HITS];
    logic [IDX_W-1:0]  truth_link_next [MAX_HITS];
    logic [IDX_W-1:0]  reco_link_reg [MAX_HITS];
    logic [IDX_W-1:0]  reco_link_next [MAX_HITS];

    logic              rec_valid_reg, rec_valid_next;
    logic [1:0]        kind_reg, kind_next;
    logic [IDX_W-1:0]  index_reg, index_next;
    logic              matched_reg, matched_next;
    logic [IDX_W-1:0]  partner_reg, partner_next;
    logic [DIST_W-1:0] distance_reg, distance_next;
    logic [CNT_W-1:0]  mc_reg, mc_next;
    logic [CNT_W-1:0]  tc_reg, tc_next;
    logic [CNT_W-1:0]  rc_reg, rc_next;
    logic              ovf_reg, ovf_next;
    logic              last_reg, last_next;

    logic              accept;
    logic              out_free;
    state_t            emit_entry;
    logic              e_last_reco;
    logic              e_last_truth;

    assign hit_stall = (state_reg != ST_IDLE);
    assign accept    = hit_valid && !hit_stall;
    assign out_free  = !rec_valid_reg || !rec_stall;

    assign truth_raddr = t_reg;
    assign reco_raddr  = r_reg;

    always_comb
    begin
        if (reco_fill_reg != '0)
        begin
            emit_entry = ST_RECO_RD;
        end
        else if (truth_fill_reg != '0)
        begin
            emit_entry = ST_TRUTH_RD;
        end
        else
        begin
            emit_entry = ST_SUM;
        end
    end

    assign e_last_reco  = ((CNT_W'(e_reg) + CNT_W'(1)) == reco_fill_reg);
    assign e_last_truth = ((CNT_W'(e_reg) + CNT_W'(1)) == truth_fill_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            truth_fill_reg <= '0;
            reco_fill_reg  <= '0;
            dropped_reg    <= 1'b0;
            nmatch_reg     <= '0;
            found_reg      <= 1'b0;
            truth_has_reg  <= '0;
            reco_has_reg   <= '0;
            rec_valid_reg  <= 1'b0;
            t_reg          <= '0;
            r_reg          <= '0;
            e_reg          <= '0;
        end
        else
        begin
            truth_fill_reg <= truth_fill_next;
            reco_fill_reg  <= reco_fill_next;
            dropped_reg    <= dropped_next;
            nmatch_reg     <= nmatch_next;
            found_reg      <= found_next;
            truth_has_reg  <= truth_has_next;
            reco_has_reg   <= reco_has_next;
            rec_valid_reg  <= rec_valid_next;
            t_reg          <= t_next;
            r_reg          <= r_next;
            e_reg          <= e_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg       <= best_next;
        bt_reg         <= bt_next;
        br_reg         <= br_next;
        truth_link_reg <= truth_link_next;
        reco_link_reg  <= reco_link_next;
        kind_reg       <= kind_next;
        index_reg      <= index_next;
        matched_reg    <= matched_next;
        partner_reg    <= partner_next;
        distance_reg   <= distance_next;
        mc_reg         <= mc_next;
        tc_reg         <= tc_next;
        rc_reg         <= rc_next;
        ovf_reg        <= ovf_next;
        last_reg       <= last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        truth_fill_next = truth_fill_reg;
        reco_fill_next  = reco_fill_reg;
        dropped_next    = dropped_reg;
        nmatch_next     = nmatch_reg;
        t_next          = t_reg;
        r_next          = r_reg;
        e_next          = e_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        bt_next         = bt_reg;
        br_next         = br_reg;
        truth_has_next  = truth_has_reg;
        reco_has_next   = reco_has_reg;
        truth_link_next = truth_link_reg;
        reco_link_next  = reco_link_reg;

        rec_valid_next  = rec_valid_reg && rec_stall;
        kind_next       = kind_reg;
        index_next      = index_reg;
        matched_next    = matched_reg;
        partner_next    = partner_reg;
        distance_next   = distance_reg;
        mc_next         = mc_reg;
        tc_next         = tc_reg;
        rc_next         = rc_reg;
        ovf_next        = ovf_reg;
        last_next       = last_reg;

        store_wr.truth_we = 1'b0;
        store_wr.reco_we  = 1'b0;
        store_wr.addr     = (func == FN_TRUTH) ? truth_fill_reg[IDX_W-1:0]
                                               : reco_fill_reg[IDX_W-1:0];
        store_wr.pos      = {coord_v, coord_u};

        dist_wr.we   = 1'b0;
        dist_wr.addr = bt_reg;
        dist_wr.dval = best_reg;

        issue.vld = 1'b0;
        issue.t   = t_reg;
        issue.r   = r_reg;

        // The distance of a reco hit's pair is kept under its truth partner.
        if (state_reg == ST_RECO_RD || state_reg == ST_RECO_PUT)
        begin
            dist_raddr = reco_link_reg[e_reg];
        end
        else
        begin
            dist_raddr = e_reg;
        end

        // Running minimum; strict compare keeps the first pair in scan order.
        if (cand.vld && (!found_reg || cand.dval < best_reg))
        begin
            found_next = 1'b1;
            best_next  = cand.dval;
            bt_next    = cand.t;
            br_next    = cand.r;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        FN_TRUTH:
                        begin
                            if (truth_fill_reg != CNT_W'(MAX_HITS))
                            begin
                                store_wr.truth_we = 1'b1;
                                truth_fill_next   = truth_fill_reg + CNT_W'(1);
                            end
                            else
                            begin
                                dropped_next = 1'b1;
                            end
                        end
                        FN_RECO:
                        begin
                            if (reco_fill_reg != CNT_W'(MAX_HITS))
                            begin
                                store_wr.reco_we = 1'b1;
                                reco_fill_next   = reco_fill_reg + CNT_W'(1);
                            end
                            else
                            begin
                                dropped_next = 1'b1;
                            end
                        end
                        FN_RUN:
                        begin
                            t_next     = '0;
                            r_next     = '0;
                            e_next     = '0;
                            found_next = 1'b0;
                            if (truth_fill_reg != '0 && reco_fill_reg != '0)
                            begin
                                state_next = ST_SCAN;
                            end
                            else
                            begin
                                state_next = emit_entry;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                issue.vld = !truth_has_reg[t_reg] && !reco_has_reg[r_reg];
                if ((CNT_W'(r_reg) + CNT_W'(1)) == reco_fill_reg)
                begin
                    r_next = '0;
                    if ((CNT_W'(t_reg) + CNT_W'(1)) == truth_fill_reg)
                    begin
                        t_next     = '0;
                        state_next = ST_DRAIN1;
                    end
                    else
                    begin
                        t_next = t_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    r_next = r_reg + IDX_W'(1);
                end
            end
            ST_DRAIN1:
            begin
                state_next = ST_DRAIN2;
            end
            ST_DRAIN2:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (found_reg && best_reg < dist_max)
                begin
                    truth_has_next[bt_reg]  = 1'b1;
                    truth_link_next[bt_reg] = br_reg;
                    reco_has_next[br_reg]   = 1'b1;
                    reco_link_next[br_reg]  = bt_reg;
                    dist_wr.we  = 1'b1;
                    nmatch_next = nmatch_reg + CNT_W'(1);
                    found_next  = 1'b0;
                    state_next  = ST_SCAN;
                end
                else
                begin
                    e_next     = '0;
                    state_next = emit_entry;
                end
            end
            ST_RECO_RD:
            begin
                state_next = ST_RECO_PUT;
            end
            ST_RECO_PUT:
            begin
                if (out_free)
                begin
                    rec_valid_next = 1'b1;
                    kind_next      = KIND_RECO;
                    index_next     = e_reg;
                    matched_next   = reco_has_reg[e_reg];
                    partner_next   = reco_has_reg[e_reg] ? reco_link_reg[e_reg] : '0;
                    distance_next  = reco_has_reg[e_reg] ? dist_rdata : '0;
                    mc_next        = '0;
                    tc_next        = '0;
                    rc_next        = '0;
                    ovf_next       = 1'b0;
                    last_next      = 1'b0;
                    if (e_last_reco)
                    begin
                        e_next     = '0;
                        state_next = (truth_fill_reg != '0) ? ST_TRUTH_RD : ST_SUM;
                    end
                    else
                    begin
                        e_next     = e_reg + IDX_W'(1);
                        state_next = ST_RECO_RD;
                    end
                end
            end
            ST_TRUTH_RD:
            begin
                state_next = ST_TRUTH_PUT;
            end
            ST_TRUTH_PUT:
            begin
                if (out_free)
                begin
                    rec_valid_next = 1'b1;
                    kind_next      = KIND_TRUTH;
                    index_next     = e_reg;
                    matched_next   = truth_has_reg[e_reg];
                    partner_next   = truth_has_reg[e_reg] ? truth_link_reg[e_reg] : '0;
                    distance_next  = truth_has_reg[e_reg] ? dist_rdata : '0;
                    mc_next        = '0;
                    tc_next        = '0;
                    rc_next        = '0;
                    ovf_next       = 1'b0;
                    last_next      = 1'b0;
                    if (e_last_truth)
                    begin
                        e_next     = '0;
                        state_next = ST_SUM;
                    end
                    else
                    begin
                        e_next     = e_reg + IDX_W'(1);
                        state_next = ST_TRUTH_RD;
                    end
                end
            end
            ST_SUM:
            begin
                if (out_free)
                begin
                    rec_valid_next  = 1'b1;
                    kind_next       = KIND_SUM;
                    index_next      = '0;
                    matched_next    = 1'b0;
                    partner_next    = '0;
                    distance_next   = '0;
                    mc_next         = nmatch_reg;
                    tc_next         = truth_fill_reg;
                    rc_next         = reco_fill_reg;
                    ovf_next        = dropped_reg;
                    last_next       = 1'b1;
                    truth_fill_next = '0;
                    reco_fill_next  = '0;
                    dropped_next    = 1'b0;
                    nmatch_next     = '0;
                    truth_has_next  = '0;
                    reco_has_next   = '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rec_valid   = rec_valid_reg;
    assign kind        = kind_reg;
    assign index       = index_reg;
    assign matched     = matched_reg;
    assign partner     = partner_reg;
    assign distance    = distance_reg;
    assign match_count = mc_reg;
    assign truth_count = tc_reg;
    assign reco_count  = rc_reg;
    assign overflow    = ovf_reg;
    assign last        = last_reg;

endmodule
`default_nettype wire

/* rtl/core/ghpm_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ghpm_checker: port-level checks of the greedy hit pair matcher
// Watches the record channel for consistent record contents over time.
// ----------------------------------------------------------------------------
module ghpm_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          hit_stall,
    input  wire logic                          rec_valid,
    input  wire logic                          rec_stall,
    input  wire logic [1:0]                    kind,
    input  wire logic                          matched,
    input  wire logic [ghpm_pkg::IDX_W-1:0]    partner,
    input  wire logic [ghpm_pkg::DIST_W-1:0]   distance,
    input  wire logic [ghpm_pkg::CNT_W-1:0]    match_count,
    input  wire logic [ghpm_pkg::CNT_W-1:0]    truth_count,
    input  wire logic [ghpm_pkg::CNT_W-1:0]    reco_count,
    input  wire logic                          last
);
    import ghpm_pkg::*;

    // A stalled record is held until taken.
    a_rec_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec_stall |=> rec_valid)
        else $error("record dropped while stalled");

    // Only the summary closes a run.
    a_last_sum: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && (last == 1'b1) |-> (kind == KIND_SUM))
        else $error("last set on a hit record");

    // Pairs cannot outnumber either store.
    a_sum_counts: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && (kind == KIND_SUM) |->
            (match_count <= truth_count) && (match_count <= reco_count))
        else $error("summary match count exceeds a fill");

    // An unpaired hit carries no partner and no distance.
    a_unmatched_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && !matched |-> (partner == '0) && (distance == '0))
        else $error("unmatched record carries pair data");

    // Records are emitted only while new hits are held off, except the summary
    // which is registered as the block returns to taking hits.
    a_stall_during_run: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && !rec_stall && (kind != KIND_SUM) |-> hit_stall)
        else $error("hits taken while run records are pending");

endmodule

bind greedy_hit_pair_matcher ghpm_checker u_ghpm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .hit_stall   (hit_stall),
    .rec_valid   (rec_valid),
    .rec_stall   (rec_stall),
    .kind        (kind),
    .matched     (matched),
    .partner     (partner),
    .distance    (distance),
    .match_count (match_count),
    .truth_count (truth_count),
    .reco_count  (reco_count),
    .last        (last)
);
`default_nettype wire
